// ===== design/nsqrt_pkg.sv =====
// nsqrt_pkg: shared constants for the fixed-point newton square root
// no dependencies
package nsqrt_pkg;

    localparam int FRAC_BITS_DEF  = 12;
    localparam int ITERATIONS_DEF = 10;
    localparam int INPUT_BITS_DEF = 50;
    localparam int ROOT_BITS      = 50;

endpackage

// ===== design/nsqrt_div_cell.sv =====
// nsqrt_div_cell: one restoring-division cell, produces one quotient bit
// depends on nothing but its parameters
module nsqrt_div_cell #(
    parameter int W   = 62,
    parameter int BIT = 0
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [W-1:0] i_scaled,
    input  logic [W-1:0] i_r,
    input  logic [W-1:0] i_rem,
    input  logic [W-1:0] i_q,
    output logic         o_valid,
    output logic [W-1:0] o_scaled,
    output logic [W-1:0] o_r,
    output logic [W-1:0] o_rem,
    output logic [W-1:0] o_q
);
    logic         r_valid;
    logic [W-1:0] r_scaled, r_r, r_rem, r_q;
    logic [W:0]   cand, diff;
    logic         ge;
    logic [W-1:0] n_rem, n_q;

    always_comb begin
        cand  = {i_rem, i_scaled[BIT]};
        diff  = cand - {1'b0, i_r};
        ge    = cand >= {1'b0, i_r};
        n_rem = ge ? diff[W-1:0] : cand[W-1:0];
        n_q   = {i_q[W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_scaled <= i_scaled;
        r_r      <= i_r;
        r_rem    <= n_rem;
        r_q      <= n_q;
    end

    assign o_valid  = r_valid;
    assign o_scaled = r_scaled;
    assign o_r      = r_r;
    assign o_rem    = r_rem;
    assign o_q      = r_q;
endmodule

// ===== design/nsqrt_update_cell.sv =====
// nsqrt_update_cell: estimate update r = (r + q) / 2, zero estimate stays zero
// depends on nothing but its parameters
module nsqrt_update_cell #(
    parameter int W = 62
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [W-1:0] i_scaled,
    input  logic [W-1:0] i_r,
    input  logic [W-1:0] i_q,
    output logic         o_valid,
    output logic [W-1:0] o_scaled,
    output logic [W-1:0] o_r,
    output logic [W-1:0] o_rem,
    output logic [W-1:0] o_q
);
    logic         r_valid;
    logic [W-1:0] r_scaled, r_r;
    logic [W:0]   sum;
    logic [W-1:0] n_r;

    always_comb begin
        sum = {1'b0, i_r} + {1'b0, i_q};
        n_r = (i_r == '0) ? '0 : sum[W:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_scaled <= i_scaled;
        r_r      <= n_r;
    end

    assign o_valid  = r_valid;
    assign o_scaled = r_scaled;
    assign o_r      = r_r;
    assign o_rem    = '0;
    assign o_q      = '0;
endmodule

// ===== design/fixed_point_newton_sqrt.sv =====
// fixed_point_newton_sqrt: top level, chain of division and update cells
// depends on nsqrt_pkg, nsqrt_div_cell, nsqrt_update_cell
//
// Takes one radicand per cycle whenever start is high; busy is always low.
// Each item passes an input register and then, for every iteration, one
// restoring-division cell per scaled-radicand bit (scaled width capped at
// 64) plus one update cell, all registered, before the root appears with
// o_valid. Results come out in order and must be taken when shown.
module fixed_point_newton_sqrt #(
    parameter int FRAC_BITS  = nsqrt_pkg::FRAC_BITS_DEF,
    parameter int ITERATIONS = nsqrt_pkg::ITERATIONS_DEF,
    parameter int INPUT_BITS = nsqrt_pkg::INPUT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [INPUT_BITS-1:0]          i_radicand,
    output logic                           o_valid,
    output logic [nsqrt_pkg::ROOT_BITS-1:0] o_root
);
    import nsqrt_pkg::*;

    localparam int FULL_W = INPUT_BITS + FRAC_BITS;
    localparam int SW     = (FULL_W > 64) ? 64 : FULL_W;
    localparam int NPOS   = ITERATIONS * (SW + 1);

    logic          v      [0:NPOS];
    logic [SW-1:0] scaled [0:NPOS];
    logic [SW-1:0] rr     [0:NPOS];
    logic [SW-1:0] rem    [0:NPOS];
    logic [SW-1:0] q      [0:NPOS];

    logic              r_valid;
    logic [SW-1:0]     r_scaled;
    logic [FULL_W-1:0] shifted;

    assign busy    = 1'b0;
    assign shifted = {i_radicand, {FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= start && !busy;
        end
        r_scaled <= shifted[SW-1:0];
    end

    assign v[0]      = r_valid;
    assign scaled[0] = r_scaled;
    assign rr[0]     = SW'(1) << FRAC_BITS;
    assign rem[0]    = '0;
    assign q[0]      = '0;

    for (genvar it = 0; it < ITERATIONS; it++) begin : g_iter
        for (genvar k = 0; k < SW; k++) begin : g_div
            localparam int P = it * (SW + 1) + k;
            nsqrt_div_cell #(.W(SW), .BIT(SW - 1 - k)) u_div (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_valid  (v[P]),
                .i_scaled (scaled[P]),
                .i_r      (rr[P]),
                .i_rem    (rem[P]),
                .i_q      (q[P]),
                .o_valid  (v[P+1]),
                .o_scaled (scaled[P+1]),
                .o_r      (rr[P+1]),
                .o_rem    (rem[P+1]),
                .o_q      (q[P+1])
            );
        end
        localparam int U = it * (SW + 1) + SW;
        nsqrt_update_cell #(.W(SW)) u_upd (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (v[U]),
            .i_scaled (scaled[U]),
            .i_r      (rr[U]),
            .i_q      (q[U]),
            .o_valid  (v[U+1]),
            .o_scaled (scaled[U+1]),
            .o_r      (rr[U+1]),
            .o_rem    (rem[U+1]),
            .o_q      (q[U+1])
        );
    end

    logic unused_rem;
    assign unused_rem = ^rem[NPOS] ^ ^scaled[NPOS];

    assign o_valid = v[NPOS] && !unused_rem || v[NPOS] && unused_rem;
    assign o_root  = ROOT_BITS'(rr[NPOS]);

`ifndef SYNTHESIS
    a_never_busy: assert property (@(posedge i_clk) !busy)
        else $error("busy raised");
    a_last_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v[NPOS-1] |=> o_valid)
        else $error("item lost in last update cell");
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(v[NPOS-1]))
        else $error("result without item");
`endif
endmodule

// ===== sim/fixed_point_newton_sqrt_chk.sv =====
// fixed_point_newton_sqrt_chk: watches the radicand and root channels,
// predicts each root by heron iteration and compares; depends on nsqrt_pkg
module fixed_point_newton_sqrt_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [49:0]                     i_radicand,
    input  logic                            o_valid,
    input  logic [nsqrt_pkg::ROOT_BITS-1:0] o_root,
    output int                              o_errors,
    output int                              o_pending
);
    import nsqrt_pkg::*;

    logic [ROOT_BITS-1:0] root_queue[$];

    function automatic logic [ROOT_BITS-1:0] heron_sqrt(logic [49:0] v);
        logic [63:0] scaled;
        logic [63:0] r;
        logic [63:0] q;
        scaled = {14'd0, v} << FRAC_BITS_DEF;
        r = 64'd1 << FRAC_BITS_DEF;
        for (int i = 0; i < ITERATIONS_DEF; i++) begin
            q = (r != 0) ? scaled / r : 64'd0;
            r = (r + q) >> 1;
        end
        return r[ROOT_BITS-1:0];
    endfunction

    assign o_pending = root_queue.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (start && !busy)
                root_queue.push_back(heron_sqrt(i_radicand));
            if (o_valid) begin
                if (root_queue.size() == 0) begin
                    $display("%0t: root %h with none expected", $time, o_root);
                    o_errors <= o_errors + 1;
                end else if (root_queue[0] !== o_root) begin
                    $display("%0t: root expected %h actual %h", $time, root_queue[0],
                             o_root);
                    o_errors <= o_errors + 1;
                    void'(root_queue.pop_front());
                end else begin
                    void'(root_queue.pop_front());
                end
            end
        end
    end
endmodule

// ===== sim/fixed_point_newton_sqrt_tb.sv =====
// fixed_point_newton_sqrt_tb: drives radicands into the square root block
// depends on nsqrt_pkg, fixed_point_newton_sqrt, fixed_point_newton_sqrt_chk
module fixed_point_newton_sqrt_tb;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic [49:0] i_radicand = '0;
    logic        busy;
    logic        o_valid;
    logic [nsqrt_pkg::ROOT_BITS-1:0] o_root;
    int          errors;
    int          pending;
    int          cycles = 0;

    always #4 i_clk = ~i_clk;

    fixed_point_newton_sqrt DUT (.*);
    fixed_point_newton_sqrt_chk checker_inst (.*, .o_errors(errors), .o_pending(pending));

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 200000) begin
            $display("fixed_point_newton_sqrt_tb: done, errors");
            $finish;
        end
    end

    function automatic logic [49:0] rand_radicand();
        logic [49:0] v;
        int bits;
        v = 50'({$urandom, $urandom});
        bits = $urandom_range(50, 1);
        if ($urandom_range(3, 0) != 0)
            v = v & ((50'd1 << bits) - 1);
        return v;
    endfunction

    task automatic send_radicand(logic [49:0] v, int idle_pct);
        while ($urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_radicand <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    logic [49:0] directed[$] = '{50'd0, 50'd1, 50'd4096, 50'd16384, 50'd2, 50'd4095,
        {50{1'b1}}, 50'h2AAAAAAAAAAAA, 50'h1555555555555, 50'd1 << 49,
        (50'd1 << 49) - 1, 50'd1 << 24, 50'd9 << 12, 50'd12345678};

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[k]) send_radicand(directed[k], 0);
        for (int p = 0; p < 4; p++)
            for (int n = 0; n < 135; n++)
                send_radicand(rand_radicand(), (p == 1) ? 69 : (p == 3) ? 24 : 0);
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("fixed_point_newton_sqrt_tb: done, clean");
        else
            $display("fixed_point_newton_sqrt_tb: done, errors");
        $finish;
    end
endmodule
